// ===== rtl/dfd_pkg.sv =====
package dfd_pkg;

  // Default build values of the top level parameters.
  localparam int PAYLOAD_BITS = 64;
  localparam int MAX_RB       = 110;
  localparam int QUEUE_DEPTH  = 2;

  // Only the leading bits of the payload carry fields; the longest format
  // (TDD, widest RIV) uses 31 of them.
  localparam int HEAD_W  = 32;
  localparam int RIV_W   = 13;
  localparam int NB_W    = 7;
  localparam int RW_W    = 4;
  localparam int LEN_W   = 6;
  localparam int MCS_W   = 5;
  localparam int HARQ_W  = 4;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = NB_W;

  localparam logic [NB_W-1:0] NUM_RB_RESET = 7'd25;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_NUM_RB   = 1'b0,
    REG_TDD_MODE = 1'b1
  } cfg_reg_t;

  // Fields split out of one request, plus the bandwidth it was split with.
  typedef struct packed {
    logic              format_flag;
    logic              vrb_distributed;
    logic [RIV_W-1:0]  riv;
    logic [NB_W-1:0]   num_rb;
    logic [MCS_W-1:0]  mcs;
    logic [HARQ_W-1:0] harq_process;
    logic              new_data;
    logic [1:0]        rv_index;
    logic [1:0]        tpc_cmd;
    logic [1:0]        dai;
    logic [LEN_W-1:0]  payload_len;
  } item_t;

  // Fully decoded grant.
  typedef struct packed {
    logic              format_flag;
    logic              vrb_distributed;
    logic [RIV_W-1:0]  riv;
    logic [NB_W-1:0]   num_rbs;
    logic [NB_W-1:0]   rb_start;
    logic [MCS_W-1:0]  mcs;
    logic [HARQ_W-1:0] harq_process;
    logic              new_data;
    logic [1:0]        rv_index;
    logic [1:0]        tpc_cmd;
    logic [1:0]        dai;
    logic [LEN_W-1:0]  payload_len;
    logic [NB_W-1:0]   bw;
  } result_t;

endpackage

// ===== rtl/dfd_front.sv =====
module dfd_front #(
  parameter int PAYLOAD_BITS = dfd_pkg::PAYLOAD_BITS,
  parameter int MAX_RB       = dfd_pkg::MAX_RB
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [dfd_pkg::CFG_INDEX_W-1:0]  cfg_addr,
  input  logic [dfd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [PAYLOAD_BITS-1:0]          dci_bits,
  input  logic                             queue_full,
  output logic                             push,
  output dfd_pkg::item_t                   push_item
);

  localparam int HEAD_W = dfd_pkg::HEAD_W;
  localparam int RIV_W  = dfd_pkg::RIV_W;
  localparam int NB_W   = dfd_pkg::NB_W;
  localparam int RW_W   = dfd_pkg::RW_W;
  localparam int LEN_W  = dfd_pkg::LEN_W;
  localparam int PW     = 2 * NB_W + 1;

  // Bits outside the RIV: flag, VRB type, MCS, HARQ, NDI, RV, TPC (and DAI).
  localparam logic [LEN_W-1:0] FDD_FIXED_BITS = LEN_W'(15);
  localparam logic [LEN_W-1:0] TDD_FIXED_BITS = LEN_W'(18);

  function automatic logic [NB_W-1:0] clamp_bw(input logic [NB_W-1:0] v);
    logic [NB_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = NB_W'(1);
    end else if (v > NB_W'(MAX_RB)) begin
      r = NB_W'(MAX_RB);
    end
    return r;
  endfunction

  // ceil(log2(n*(n+1)/2)): the last power of two still below the triangle
  // number sets the width.
  function automatic logic [RW_W-1:0] riv_width(input logic [NB_W-1:0] n);
    logic [NB_W:0]   n1;
    logic [PW-1:0]   prod;
    logic [PW-1:0]   tri_num;
    logic [RW_W-1:0] w;
    n1      = {1'b0, n} + 1'b1;
    prod    = PW'(n) * PW'(n1);
    tri_num = prod >> 1;
    w       = '0;
    for (int i = 0; i < RIV_W; i++) begin
      if ((PW'(1) << i) < tri_num) begin
        w = RW_W'(i + 1);
      end
    end
    return w;
  endfunction

  function automatic logic ambiguous_len(input logic [LEN_W-1:0] len);
    return (len == LEN_W'(12)) || (len == LEN_W'(14)) || (len == LEN_W'(16)) ||
           (len == LEN_W'(20)) || (len == LEN_W'(24)) || (len == LEN_W'(26)) ||
           (len == LEN_W'(32)) || (len == LEN_W'(40)) || (len == LEN_W'(44)) ||
           (len == LEN_W'(56));
  endfunction

  logic [NB_W-1:0] bw;
  logic [RW_W-1:0] rw;
  logic            tdd;

  always_ff @(posedge clk) begin
    if (rst) begin
      bw  <= clamp_bw(dfd_pkg::NUM_RB_RESET);
      rw  <= riv_width(clamp_bw(dfd_pkg::NUM_RB_RESET));
      tdd <= 1'b0;
    end else if (cfg_wr_en) begin
      case (dfd_pkg::cfg_reg_t'(cfg_addr))
        dfd_pkg::REG_NUM_RB: begin
          bw <= clamp_bw(cfg_data[NB_W-1:0]);
          rw <= riv_width(clamp_bw(cfg_data[NB_W-1:0]));
        end
        dfd_pkg::REG_TDD_MODE: begin
          tdd <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  logic [HEAD_W-1:0] head;
  logic [RIV_W-1:0]  riv_win;
  logic [RW_W-1:0]   riv_shift;
  logic [RW_W:0]     tail_shift;
  logic [HEAD_W-1:0] tail;
  logic [LEN_W-1:0]  pos;

  always_comb begin
    head       = dci_bits[PAYLOAD_BITS-1 -: HEAD_W];
    riv_win    = head[HEAD_W-3 -: RIV_W];
    riv_shift  = RW_W'(RIV_W) - rw;
    tail_shift = (RW_W+1)'(rw) + (RW_W+1)'(2);
    tail       = head << tail_shift;
    pos        = LEN_W'(rw) + (tdd ? TDD_FIXED_BITS : FDD_FIXED_BITS);

    push_item.format_flag     = head[HEAD_W-1];
    push_item.vrb_distributed = head[HEAD_W-2];
    push_item.riv             = riv_win >> riv_shift;
    push_item.num_rb          = bw;
    push_item.mcs             = tail[HEAD_W-1 -: dfd_pkg::MCS_W];
    if (tdd) begin
      push_item.harq_process = tail[HEAD_W-6 -: 4];
      push_item.new_data     = tail[HEAD_W-10];
      push_item.rv_index     = tail[HEAD_W-11 -: 2];
      push_item.tpc_cmd      = tail[HEAD_W-13 -: 2];
      push_item.dai          = tail[HEAD_W-15 -: 2];
    end else begin
      push_item.harq_process = {1'b0, tail[HEAD_W-6 -: 3]};
      push_item.new_data     = tail[HEAD_W-9];
      push_item.rv_index     = tail[HEAD_W-10 -: 2];
      push_item.tpc_cmd      = tail[HEAD_W-12 -: 2];
      push_item.dai          = 2'b00;
    end
    // A payload that would land on an ambiguous size carries one pad bit.
    push_item.payload_len = ambiguous_len(pos) ? pos + 1'b1 : pos;
  end

  assign in_ready = !queue_full;
  assign push     = in_valid && !queue_full;

  a_len_not_ambiguous: assert property (@(posedge clk) disable iff (rst)
    push |-> !ambiguous_len(push_item.payload_len))
    else $error("decoded length sits on an ambiguous size");

endmodule

// ===== rtl/dfd_queue.sv =====
module dfd_queue #(
  parameter int DEPTH = dfd_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dfd_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output dfd_pkg::item_t head_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dfd_pkg::item_t   slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond its depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !head_valid))
    else $error("queue read while empty");

endmodule

// ===== rtl/dfd_back.sv =====
module dfd_back #(
  parameter int MAX_RB = dfd_pkg::MAX_RB
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  dfd_pkg::item_t   head_item,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output dfd_pkg::result_t result
);

  localparam int RIV_W = dfd_pkg::RIV_W;
  localparam int NB_W  = dfd_pkg::NB_W;
  // The RIV stays below n*(n+1), so the quotient needs QW bits.
  localparam int QW    = $clog2(MAX_RB + 1);
  localparam int DW    = RIV_W + QW;

  logic             advance;
  logic             st_vld  [QW];
  dfd_pkg::item_t   st_item [QW];
  logic [RIV_W-1:0] st_rem  [QW];
  logic [QW-1:0]    st_quo  [QW];

  logic             in_vld  [QW];
  dfd_pkg::item_t   in_item [QW];
  logic [RIV_W-1:0] rem_in  [QW];
  logic [QW-1:0]    quo_in  [QW];
  logic [RIV_W-1:0] rem_nx  [QW];
  logic [QW-1:0]    quo_nx  [QW];

  // The whole pipe moves together; it only holds when a finished grant waits.
  assign advance = !out_valid || out_ready;
  assign pop     = head_valid && advance;

  always_comb begin
    in_vld[0]  = head_valid;
    in_item[0] = head_item;
    rem_in[0]  = head_item.riv;
    quo_in[0]  = '0;
    for (int s = 1; s < QW; s++) begin
      in_vld[s]  = st_vld[s-1];
      in_item[s] = st_item[s-1];
      rem_in[s]  = st_rem[s-1];
      quo_in[s]  = st_quo[s-1];
    end
  end

  // Restoring division, one quotient bit per stage, most significant first.
  always_comb begin
    logic [DW-1:0] rext;
    logic [DW-1:0] dsh;
    for (int s = 0; s < QW; s++) begin
      rext = DW'(rem_in[s]);
      dsh  = DW'(in_item[s].num_rb) << (QW - 1 - s);
      if (rext >= dsh) begin
        rem_nx[s] = RIV_W'(rext - dsh);
        quo_nx[s] = quo_in[s] | (QW'(1) << (QW - 1 - s));
      end else begin
        rem_nx[s] = rem_in[s];
        quo_nx[s] = quo_in[s];
      end
    end
  end

  dfd_pkg::item_t   fin;
  logic [QW-1:0]    q;
  logic [NB_W-1:0]  r;
  logic [NB_W+1:0]  ab;
  logic             wrap;
  dfd_pkg::result_t res_nx;

  always_comb begin
    fin  = st_item[QW-1];
    q    = st_quo[QW-1];
    r    = st_rem[QW-1][NB_W-1:0];
    ab   = (NB_W+2)'(q) + (NB_W+2)'(r) + (NB_W+2)'(1);
    wrap = ab > (NB_W+2)'(fin.num_rb);

    res_nx.format_flag     = fin.format_flag;
    res_nx.vrb_distributed = fin.vrb_distributed;
    res_nx.riv             = fin.riv;
    res_nx.mcs             = fin.mcs;
    res_nx.harq_process    = fin.harq_process;
    res_nx.new_data        = fin.new_data;
    res_nx.rv_index        = fin.rv_index;
    res_nx.tpc_cmd         = fin.tpc_cmd;
    res_nx.dai             = fin.dai;
    res_nx.payload_len     = fin.payload_len;
    res_nx.bw              = fin.num_rb;
    // Lengths past the midpoint are coded mirrored.
    if (wrap) begin
      res_nx.num_rbs  = NB_W'((NB_W+1)'(fin.num_rb) + (NB_W+1)'(1) - (NB_W+1)'(q));
      res_nx.rb_start = fin.num_rb - NB_W'(1) - r;
    end else begin
      res_nx.num_rbs  = NB_W'((NB_W+1)'(q) + (NB_W+1)'(1));
      res_nx.rb_start = r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < QW; s++) begin
        st_vld[s] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (advance) begin
      for (int s = 0; s < QW; s++) begin
        st_vld[s] <= in_vld[s];
      end
      out_valid <= st_vld[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int s = 0; s < QW; s++) begin
        st_item[s] <= in_item[s];
        st_rem[s]  <= rem_nx[s];
        st_quo[s]  <= quo_nx[s];
      end
      result <= res_nx;
    end
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    st_vld[QW-1] |-> (st_rem[QW-1] < RIV_W'(st_item[QW-1].num_rb)))
    else $error("division remainder not below the bandwidth");

  a_alloc_in_band: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (result.num_rbs != '0) && (result.rb_start < result.bw))
    else $error("decoded allocation outside the band");

endmodule

// ===== rtl/dci_format_1a_field_decode_core.sv =====
// Channel    Direction  Signals                              Accepted when
// config     in         cfg_wr_en, cfg_addr, cfg_data        cfg_wr_en high
// request    in         in_valid, in_ready, dci_bits         in_valid && in_ready
// grant      out        out_valid, out_ready, decoded fields out_valid && out_ready
//
// One request is taken per cycle and one grant leaves per cycle while out_ready holds.
// A request passes through the queue, the one-bit-per-stage RIV divider in the back end
// and the output register on its way to a grant.
// Reset sets the bandwidth to 25 RBs and FDD, and empties the queue and the pipeline.
// A stalled grant freezes the back end; the queue then fills up to QUEUE_DEPTH requests
// before in_ready drops.
module dci_format_1a_field_decode_core #(
  parameter int PAYLOAD_BITS = dfd_pkg::PAYLOAD_BITS,
  parameter int MAX_RB       = dfd_pkg::MAX_RB,
  parameter int QUEUE_DEPTH  = dfd_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,

  input  logic                             cfg_wr_en,
  input  logic [dfd_pkg::CFG_INDEX_W-1:0]  cfg_addr,
  input  logic [dfd_pkg::CFG_DATA_W-1:0]   cfg_data,

  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [PAYLOAD_BITS-1:0]          dci_bits,

  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             format_flag,
  output logic                             vrb_distributed,
  output logic [dfd_pkg::RIV_W-1:0]        riv,
  output logic [dfd_pkg::NB_W-1:0]         num_rbs,
  output logic [dfd_pkg::NB_W-1:0]         rb_start,
  output logic [dfd_pkg::MCS_W-1:0]        mcs,
  output logic [dfd_pkg::HARQ_W-1:0]       harq_process,
  output logic                             new_data,
  output logic [1:0]                       rv_index,
  output logic [1:0]                       tpc_cmd,
  output logic [1:0]                       dai,
  output logic [dfd_pkg::LEN_W-1:0]        payload_len
);

  // The front end holds the configuration and slices each request into its
  // fields in the cycle it arrives. The RIV width follows the bandwidth and
  // is worked out once, when the bandwidth register is written.
  logic             push;
  logic             queue_full;
  dfd_pkg::item_t   push_item;

  // The queue decouples slicing from division so that a stalled consumer
  // does not immediately stall the producer.
  logic             head_valid;
  logic             pop;
  dfd_pkg::item_t   head_item;

  // The back end divides the RIV by the bandwidth and unfolds the mirrored
  // coding into length and start.
  dfd_pkg::result_t result;

  dfd_front #(
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .MAX_RB       (MAX_RB)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .dci_bits   (dci_bits),
    .queue_full (queue_full),
    .push       (push),
    .push_item  (push_item)
  );

  dfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  dfd_back #(
    .MAX_RB (MAX_RB)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result     (result)
  );

  // The bandwidth copy in the result only serves checking inside the back end.
  assign format_flag     = result.format_flag;
  assign vrb_distributed = result.vrb_distributed;
  assign riv             = result.riv;
  assign num_rbs         = result.num_rbs;
  assign rb_start        = result.rb_start;
  assign mcs             = result.mcs;
  assign harq_process    = result.harq_process;
  assign new_data        = result.new_data;
  assign rv_index        = result.rv_index;
  assign tpc_cmd         = result.tpc_cmd;
  assign dai             = result.dai;
  assign payload_len     = result.payload_len;

endmodule

// ===== tb/sv/dfd_grant_checker.sv =====
// Watches the request and grant channels of the format 1A decoder, predicts
// each grant from the request payload and the bandwidth and frame type in
// force when the request was taken, and compares grants in order.
module dfd_grant_checker (
  input  logic                              clk,
  input  logic                              rst,

  input  logic                              cfg_wr_en,
  input  logic [dfd_pkg::CFG_INDEX_W-1:0]   cfg_addr,
  input  logic [dfd_pkg::CFG_DATA_W-1:0]    cfg_data,

  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [dfd_pkg::PAYLOAD_BITS-1:0]  dci_bits,

  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic                              format_flag,
  input  logic                              vrb_distributed,
  input  logic [dfd_pkg::RIV_W-1:0]         riv,
  input  logic [dfd_pkg::NB_W-1:0]          num_rbs,
  input  logic [dfd_pkg::NB_W-1:0]          rb_start,
  input  logic [dfd_pkg::MCS_W-1:0]         mcs,
  input  logic [dfd_pkg::HARQ_W-1:0]        harq_process,
  input  logic                              new_data,
  input  logic [1:0]                        rv_index,
  input  logic [1:0]                        tpc_cmd,
  input  logic [1:0]                        dai,
  input  logic [dfd_pkg::LEN_W-1:0]         payload_len,

  output int                                mismatches,
  output int                                pending_grants
);

  localparam int PAYLOAD_BITS = dfd_pkg::PAYLOAD_BITS;
  localparam int MAX_RB       = dfd_pkg::MAX_RB;
  localparam int RIV_W        = dfd_pkg::RIV_W;
  localparam int NB_W         = dfd_pkg::NB_W;
  localparam int MCS_W        = dfd_pkg::MCS_W;
  localparam int HARQ_W       = dfd_pkg::HARQ_W;
  localparam int LEN_W        = dfd_pkg::LEN_W;

  typedef struct packed {
    logic              format_flag;
    logic              vrb_distributed;
    logic [RIV_W-1:0]  riv;
    logic [NB_W-1:0]   num_rbs;
    logic [NB_W-1:0]   rb_start;
    logic [MCS_W-1:0]  mcs;
    logic [HARQ_W-1:0] harq_process;
    logic              new_data;
    logic [1:0]        rv_index;
    logic [1:0]        tpc_cmd;
    logic [1:0]        dai;
    logic [LEN_W-1:0]  payload_len;
  } grant_t;

  grant_t          expected_grants[$];
  logic [NB_W-1:0] bw_cfg;
  logic            tdd_cfg;
  int              fail_count = 0;

  // Field of the given width that starts pos bits after the first payload bit.
  function automatic int unsigned pick(input logic [PAYLOAD_BITS-1:0] w,
                                       input int unsigned pos, input int unsigned wd);
    logic [PAYLOAD_BITS-1:0] mask;
    if (wd == 0) return 0;
    mask = (64'd1 << wd) - 64'd1;
    return 32'((w >> (PAYLOAD_BITS - pos - wd)) & mask);
  endfunction

  function automatic grant_t decode_grant(input logic [PAYLOAD_BITS-1:0] w,
                                          input logic [NB_W-1:0] bw_reg, input logic tdd);
    int unsigned n, pos, rw, riv_val, quo, rem, len, st, hw;
    grant_t g;
    n = 32'(bw_reg);
    if (n == 0) n = 1;
    if (n > MAX_RB) n = MAX_RB;
    rw = 0;
    while ((1 << rw) < (n * (n + 1)) / 2) rw++;

    g = '0;
    g.format_flag     = 1'(pick(w, 0, 1));
    g.vrb_distributed = 1'(pick(w, 1, 1));
    riv_val = pick(w, 2, rw);
    pos = 2 + rw;

    // Out-of-range values go through the same rule; only the mirror branch
    // differs from a plain quotient and remainder.
    quo = riv_val / n + 1;
    rem = riv_val % n;
    if (quo + rem > n) begin
      len = n + 2 - quo;
      st  = n - 1 - rem;
    end else begin
      len = quo;
      st  = rem;
    end
    g.riv      = RIV_W'(riv_val);
    g.num_rbs  = NB_W'(len);
    g.rb_start = NB_W'(st);

    g.mcs = MCS_W'(pick(w, pos, 5));
    pos += 5;
    hw = tdd ? 4 : 3;
    g.harq_process = HARQ_W'(pick(w, pos, hw));
    pos += hw;
    g.new_data = 1'(pick(w, pos, 1));
    pos += 1;
    g.rv_index = 2'(pick(w, pos, 2));
    pos += 2;
    g.tpc_cmd = 2'(pick(w, pos, 2));
    pos += 2;
    if (tdd) begin
      g.dai = 2'(pick(w, pos, 2));
      pos += 2;
    end
    if (pos inside {12, 14, 16, 20, 24, 26, 32, 40, 44, 56}) pos += 1;
    g.payload_len = LEN_W'(pos);
    return g;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    grant_t want;
    if (rst) begin
      bw_cfg  <= dfd_pkg::NUM_RB_RESET;
      tdd_cfg <= 1'b0;
      expected_grants.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_grants.size() == 0) begin
          $error("grant with no request outstanding");
          fail_count++;
        end else begin
          want = expected_grants.pop_front();
          check_field("format_flag", want.format_flag, format_flag);
          check_field("vrb_distributed", want.vrb_distributed, vrb_distributed);
          check_field("riv", want.riv, riv);
          check_field("num_rbs", want.num_rbs, num_rbs);
          check_field("rb_start", want.rb_start, rb_start);
          check_field("mcs", want.mcs, mcs);
          check_field("harq_process", want.harq_process, harq_process);
          check_field("new_data", want.new_data, new_data);
          check_field("rv_index", want.rv_index, rv_index);
          check_field("tpc_cmd", want.tpc_cmd, tpc_cmd);
          check_field("dai", want.dai, dai);
          check_field("payload_len", want.payload_len, payload_len);
        end
      end
      if (in_valid && in_ready)
        expected_grants.push_back(decode_grant(dci_bits, bw_cfg, tdd_cfg));
      if (cfg_wr_en) begin
        if (cfg_addr == dfd_pkg::REG_NUM_RB) bw_cfg <= cfg_data;
        else if (cfg_addr == dfd_pkg::REG_TDD_MODE) tdd_cfg <= cfg_data[0];
      end
    end
    mismatches     <= fail_count;
    pending_grants <= expected_grants.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the format 1A decoder bench. It builds the clock and the reset,
// drives the configuration port and the request channel, stalls the grant
// channel, and gives the verdict. All prediction and comparison is done in
// the checker instance beside the block.
module tb_top;

  localparam int PAYLOAD_BITS = dfd_pkg::PAYLOAD_BITS;
  localparam int MAX_RB       = dfd_pkg::MAX_RB;
  localparam int CFG_DATA_W   = dfd_pkg::CFG_DATA_W;
  localparam int RIV_W        = dfd_pkg::RIV_W;
  localparam int NB_W         = dfd_pkg::NB_W;
  localparam int MCS_W        = dfd_pkg::MCS_W;
  localparam int HARQ_W       = dfd_pkg::HARQ_W;
  localparam int LEN_W        = dfd_pkg::LEN_W;

  // The decoder's latency from a request to its grant, from the RIV divider
  // depth plus the queue and the output register.
  localparam int GRANT_LATENCY = $clog2(MAX_RB + 1) + 2;
  // Cycles with no request, grant or register write before the run is
  // declared hung. The slowest legal stretch is a grant held back by the
  // heaviest receiver stall.
  localparam int HANG_LIMIT = 2000;
  localparam int RANDOM_PER_PHASE = 33;
  localparam int NUM_PHASES = 12;

  // Receiver stall behaviors; each one holds for a random stretch of cycles.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_RANDOM,
    RX_STARVED
  } rx_mode_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;

  logic                    cfg_wr_en = 1'b0;
  dfd_pkg::cfg_reg_t       cfg_addr = dfd_pkg::REG_NUM_RB;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [PAYLOAD_BITS-1:0] dci_bits = '0;

  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    format_flag;
  logic                    vrb_distributed;
  logic [RIV_W-1:0]        riv;
  logic [NB_W-1:0]         num_rbs;
  logic [NB_W-1:0]         rb_start;
  logic [MCS_W-1:0]        mcs;
  logic [HARQ_W-1:0]       harq_process;
  logic                    new_data;
  logic [1:0]              rv_index;
  logic [1:0]              tpc_cmd;
  logic [1:0]              dai;
  logic [LEN_W-1:0]        payload_len;

  int                      mismatches;
  int                      pending_grants;

  always #5 clk = ~clk;

  dci_format_1a_field_decode_core u_dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_addr          (cfg_addr),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .dci_bits          (dci_bits),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .format_flag       (format_flag),
    .vrb_distributed   (vrb_distributed),
    .riv               (riv),
    .num_rbs           (num_rbs),
    .rb_start          (rb_start),
    .mcs               (mcs),
    .harq_process      (harq_process),
    .new_data          (new_data),
    .rv_index          (rv_index),
    .tpc_cmd           (tpc_cmd),
    .dai               (dai),
    .payload_len       (payload_len)
  );

  dfd_grant_checker u_checker (
    .clk               (clk),
    .rst               (rst),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_addr          (cfg_addr),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .dci_bits          (dci_bits),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .format_flag       (format_flag),
    .vrb_distributed   (vrb_distributed),
    .riv               (riv),
    .num_rbs           (num_rbs),
    .rb_start          (rb_start),
    .mcs               (mcs),
    .harq_process      (harq_process),
    .new_data          (new_data),
    .rv_index          (rv_index),
    .tpc_cmd           (tpc_cmd),
    .dai               (dai),
    .payload_len       (payload_len),
    .mismatches        (mismatches),
    .pending_grants    (pending_grants)
  );

  // The grant side picks a stall behavior, keeps it for a random number of
  // cycles, then picks again. Open stretches let the pipeline run at full
  // rate; starved stretches back the queue up until in_ready drops.
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 2));
      rx_left <= $urandom_range(16, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
      default:   out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Hang detector: any accepted request, accepted grant or register write
  // counts as progress.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HANG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // The sender works in bursts. At the start of each burst it may drop
  // in_valid for a random gap; within a burst requests go back to back with
  // in_valid held high, so only the payload changes between them.
  int burst_left = 0;

  task automatic send_request(input logic [PAYLOAD_BITS-1:0] bits);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 8);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    dci_bits <= bits;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop sending and wait for every predicted grant to come back. The
  // checker's count is registered, so the task steps the clock before it reads it.
  task automatic drain_grants();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_grants != 0);
  endtask

  // Presents one register write and waits for the clock edge. The write enable stays high so
  // that writes can follow back to back; the caller drops it after the last.
  task automatic write_reg(input dfd_pkg::cfg_reg_t idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Bandwidth and frame type for each phase. The fixed ones cover a single
  // RB, the widest band, a zero and two oversize bandwidths (which the block
  // clamps), and the sizes whose payload length lands on an ambiguous size
  // in FDD or TDD. The last three phases draw a random setting.
  logic [NB_W-1:0] bw_plan  [9] = '{7'd1, 7'd110, 7'd0, 7'd127, 7'd6, 7'd2, 7'd50, 7'd20,
                                    7'd111};
  logic            tdd_plan [9] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

  // Directed payloads under the reset setting of 25 RBs in FDD: all zeros and
  // all ones, the two alternating patterns, the format flag alone, the VRB
  // flag alone, every field bit set with both flags clear (an RIV beyond the
  // valid set), and only the unused tail bits set, which must not show up.
  logic [PAYLOAD_BITS-1:0] directed_bits [8] = '{
    64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
    64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
    64'h8000_0000_0000_0000, 64'h4000_0000_0000_0000,
    64'h3FFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF
  };

  initial begin
    logic [NB_W-1:0] bw;
    logic            tdd;

    // Synchronous reset held from time zero, then released once.
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_bits[i]) send_request(directed_bits[i]);

    for (int p = 0; p < NUM_PHASES; p++) begin
      // Registers change only with the block empty; the drain also stands as
      // the sender's pause until every outstanding grant has returned.
      drain_grants();
      if (p < 9) begin
        bw  = bw_plan[p];
        tdd = tdd_plan[p];
      end else begin
        bw  = NB_W'($urandom_range(0, 127));
        tdd = 1'($urandom_range(0, 1));
      end
      write_reg(dfd_pkg::REG_NUM_RB, bw);
      write_reg(dfd_pkg::REG_TDD_MODE, {{(CFG_DATA_W-1){1'b0}}, tdd});
      cfg_wr_en <= 1'b0;

      // A request's decode depends only on its payload and the settings, so fully random payloads reach every field
      // value and both branches of the RIV decode.
      repeat (RANDOM_PER_PHASE) send_request({$urandom, $urandom});
    end

    drain_grants();
    // Any stray grant after the last expected one is caught in this window.
    repeat (4 * GRANT_LATENCY) @(posedge clk);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
